// File: src/nnis_pkg.sv
// Shared types and constants of the nearest-neighbor image scaler.
package nnis_pkg;

    // Fixed field widths
    localparam int WORD_W     = 32;
    localparam int COORD_W    = 12;
    localparam int SRC_SIZE_W = 9;
    localparam int DST_SIZE_W = 13;
    localparam int PROD_W     = COORD_W + SRC_SIZE_W;
    localparam int QUO_W      = SRC_SIZE_W;
    localparam int REM_W      = DST_SIZE_W;
    localparam int DIV_CNT_W  = $clog2(QUO_W);
    localparam int DST_LIMIT  = 4096;

    // Register port
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Command queue between front and back
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_DST_WIDTH  = 2'd2,
        REG_DST_HEIGHT = 2'd3
    } reg_idx_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_FETCH = 1'b1
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [WORD_W-1:0]  pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] pixel_out;
        logic              status;
    } out_word_t;

    // Configured sizes after clamping to their legal ranges
    typedef struct packed {
        logic [SRC_SIZE_W-1:0] src_width;
        logic [SRC_SIZE_W-1:0] src_height;
        logic [DST_SIZE_W-1:0] dst_width;
        logic [DST_SIZE_W-1:0] dst_height;
    } cfg_t;

    typedef enum logic [1:0] {
        CMD_ERROR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_FETCH = 2'd2
    } cmd_kind_t;

    // col/row: source coordinate on load, x*src_width / y*src_height on fetch
    typedef struct packed {
        cmd_kind_t         kind;
        logic [PROD_W-1:0] col;
        logic [PROD_W-1:0] row;
        logic [WORD_W-1:0] pixel;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] dvd;
    } div_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_DIV  = 2'd1,
        BK_READ = 2'd2,
        BK_DATA = 2'd3
    } back_state_t;

    // One restoring division step: dividend bits shift out at the top,
    // quotient bits shift in at the bottom.
    function automatic div_t div_step(input div_t cur, input logic [DST_SIZE_W-1:0] dv);
        logic [REM_W:0] trial;
        logic           ge;
        div_t           nxt;
        trial = {cur.rem, cur.dvd[QUO_W-1]};
        ge    = (trial >= {1'b0, dv});
        nxt.rem = ge ? REM_W'(trial - {1'b0, dv}) : trial[REM_W-1:0];
        nxt.dvd = {cur.dvd[QUO_W-2:0], ge};
        return nxt;
    endfunction

endpackage

// File: src/nnis_regs.sv
// Configuration register file with APB-style access and size clamping.
module nnis_regs
    import nnis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [SRC_SIZE_W-1:0] src_width_reg;
    logic [SRC_SIZE_W-1:0] src_height_reg;
    logic [DST_SIZE_W-1:0] dst_width_reg;
    logic [DST_SIZE_W-1:0] dst_height_reg;
    logic                  wr_en;
    reg_idx_t              idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_SIZE_W'(256);
            src_height_reg <= SRC_SIZE_W'(256);
            dst_width_reg  <= DST_SIZE_W'(256);
            dst_height_reg <= DST_SIZE_W'(256);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SRC_WIDTH:  src_width_reg  <= pwdata[SRC_SIZE_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= pwdata[SRC_SIZE_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= pwdata[DST_SIZE_W-1:0];
                REG_DST_HEIGHT: dst_height_reg <= pwdata[DST_SIZE_W-1:0];
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            REG_SRC_WIDTH:  prdata = PDATA_W'(src_width_reg);
            REG_SRC_HEIGHT: prdata = PDATA_W'(src_height_reg);
            REG_DST_WIDTH:  prdata = PDATA_W'(dst_width_reg);
            REG_DST_HEIGHT: prdata = PDATA_W'(dst_height_reg);
        endcase
    end

    // Zero acts as one, oversize acts as the limit
    always_comb
    begin
        if (src_width_reg == '0)
            cfg.src_width = SRC_SIZE_W'(1);
        else if (DST_SIZE_W'(src_width_reg) > DST_SIZE_W'(MAX_WIDTH))
            cfg.src_width = SRC_SIZE_W'(MAX_WIDTH);
        else
            cfg.src_width = src_width_reg;

        if (src_height_reg == '0)
            cfg.src_height = SRC_SIZE_W'(1);
        else if (DST_SIZE_W'(src_height_reg) > DST_SIZE_W'(MAX_HEIGHT))
            cfg.src_height = SRC_SIZE_W'(MAX_HEIGHT);
        else
            cfg.src_height = src_height_reg;

        if (dst_width_reg == '0)
            cfg.dst_width = DST_SIZE_W'(1);
        else if (dst_width_reg > DST_SIZE_W'(DST_LIMIT))
            cfg.dst_width = DST_SIZE_W'(DST_LIMIT);
        else
            cfg.dst_width = dst_width_reg;

        if (dst_height_reg == '0)
            cfg.dst_height = DST_SIZE_W'(1);
        else if (dst_height_reg > DST_SIZE_W'(DST_LIMIT))
            cfg.dst_height = DST_SIZE_W'(DST_LIMIT);
        else
            cfg.dst_height = dst_height_reg;
    end

endmodule

// File: src/nnis_front.sv
// Input front end: range checks, classification and coordinate products.
module nnis_front
    import nnis_pkg::*;
(
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_data,
    input  cfg_t      cfg,
    input  q_status_t q_status,
    output logic      push,
    output cmd_t      push_cmd
);

    logic load_bad;
    logic fetch_bad;

    assign in_stall = q_status.full;
    assign push     = in_valid && !q_status.full;

    // Bounds against source size on load, destination size on fetch
    assign load_bad  = (DST_SIZE_W'(in_data.x) >= DST_SIZE_W'(cfg.src_width)) ||
                       (DST_SIZE_W'(in_data.y) >= DST_SIZE_W'(cfg.src_height));
    assign fetch_bad = (DST_SIZE_W'(in_data.x) >= cfg.dst_width) ||
                       (DST_SIZE_W'(in_data.y) >= cfg.dst_height);

    // Build the command word
    always_comb
    begin
        push_cmd.pixel = in_data.pixel_in;
        if (in_data.op == OP_FETCH)
        begin
            push_cmd.kind = fetch_bad ? CMD_ERROR : CMD_FETCH;
            push_cmd.col  = PROD_W'(in_data.x) * PROD_W'(cfg.src_width);
            push_cmd.row  = PROD_W'(in_data.y) * PROD_W'(cfg.src_height);
        end
        else
        begin
            push_cmd.kind = load_bad ? CMD_ERROR : CMD_LOAD;
            push_cmd.col  = PROD_W'(in_data.x);
            push_cmd.row  = PROD_W'(in_data.y);
        end
    end

endmodule

// File: src/nnis_queue.sv
// Short command queue between the front end and the back end.
module nnis_queue
    import nnis_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head,
    output q_status_t q_status
);

    cmd_t               entry_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;

    assign q_status.full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign head           = entry_mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_mem[wr_ptr_reg] <= push_cmd;
    end

    // No write into a full queue, no read from an empty one
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_status.full || pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("queue read while empty");

endmodule

// File: src/nnis_back.sv
// Back end: frame store, coordinate dividers and result register.
module nnis_back
    import nnis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  cmd_t      head,
    input  q_status_t q_status,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [PIXEL_BITS-1:0] frame_mem [DEPTH];
    logic [PIXEL_BITS-1:0] rd_reg;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    div_t                 div_x_reg;
    div_t                 div_x_next;
    div_t                 div_y_reg;
    div_t                 div_y_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_word_t            out_reg;
    out_word_t            out_next;

    logic                  slot_free;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_addr;
    logic [SRC_SIZE_W-1:0] src_col;
    logic [SRC_SIZE_W-1:0] src_row;

    assign slot_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Quotients clamped to the last source column and row
    assign src_col = (div_x_reg.dvd >= cfg.src_width)  ? cfg.src_width - 1'b1
                                                       : div_x_reg.dvd;
    assign src_row = (div_y_reg.dvd >= cfg.src_height) ? cfg.src_height - 1'b1
                                                       : div_y_reg.dvd;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        div_x_next     = div_x_reg;
        div_y_next     = div_y_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        pop            = 1'b0;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_addr       = AW'(head.row) * AW'(MAX_WIDTH) + AW'(head.col);

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    unique case (head.kind)
                        CMD_FETCH:
                        begin
                            pop            = 1'b1;
                            div_x_next.rem = REM_W'(head.col[PROD_W-1:QUO_W]);
                            div_x_next.dvd = head.col[QUO_W-1:0];
                            div_y_next.rem = REM_W'(head.row[PROD_W-1:QUO_W]);
                            div_y_next.dvd = head.row[QUO_W-1:0];
                            cnt_next       = '0;
                            state_next     = BK_DIV;
                        end
                        CMD_LOAD:
                        begin
                            if (slot_free)
                            begin
                                pop                = 1'b1;
                                mem_we             = 1'b1;
                                out_valid_next     = 1'b1;
                                out_next.pixel_out = '0;
                                out_next.status    = STATUS_OK;
                            end
                        end
                        default:
                        begin
                            if (slot_free)
                            begin
                                pop                = 1'b1;
                                out_valid_next     = 1'b1;
                                out_next.pixel_out = '0;
                                out_next.status    = STATUS_RANGE;
                            end
                        end
                    endcase
                end
            end
            BK_DIV:
            begin
                div_x_next = div_step(div_x_reg, cfg.dst_width);
                div_y_next = div_step(div_y_reg, cfg.dst_height);
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(QUO_W - 1))
                    state_next = BK_READ;
            end
            BK_READ:
            begin
                mem_re     = 1'b1;
                mem_addr   = AW'(src_row) * AW'(MAX_WIDTH) + AW'(src_col);
                state_next = BK_DATA;
            end
            BK_DATA:
            begin
                if (slot_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.pixel_out = WORD_W'(rd_reg);
                    out_next.status    = STATUS_OK;
                    state_next         = BK_IDLE;
                end
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        div_x_reg <= div_x_next;
        div_y_reg <= div_y_next;
        out_reg   <= out_next;
    end

    // Frame store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[mem_addr] <= head.pixel[PIXEL_BITS-1:0];
        if (mem_re)
            rd_reg <= frame_mem[mem_addr];
    end

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(out_reg)))
        else $error("pending result overwritten");
    // Division finishes after one step per quotient bit
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_DIV && cnt_reg == DIV_CNT_W'(QUO_W - 1)) |=> state_reg == BK_READ)
        else $error("divider step count wrong");
    // In-range destination coordinates map inside the source image
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |-> (div_x_reg.dvd < cfg.src_width &&
                                    div_y_reg.dvd < cfg.src_height))
        else $error("quotient beyond source size");

endmodule

// File: src/nearest_neighbor_image_scaler.sv
// Top level of the nearest-neighbor image scaler.
//
// Input channel (in_valid/in_stall/in_data) takes one word per item: op 0
// loads pixel_in into the frame store at source (x, y); op 1 fetches the
// source pixel that destination (x, y) maps to. Every item gives exactly
// one result word on the output channel (out_valid/out_stall/out_data):
// pixel 0 with status 0 for a good load, the stored pixel for a good fetch,
// pixel 0 with status 1 for a coordinate outside the configured sizes.
// Sizes are to be written over the APB-style port only while the block is
// idle; the block itself does not enforce this. A front end checks ranges and
// forms x*src_width, y*src_height; a two-entry queue feeds the back end. A
// fetch in the back end pops the queue, runs nine divider steps (one quotient
// bit per cycle, column and row in parallel), then the BK_READ and BK_DATA
// states read the registered frame store; loads and range errors are answered
// straight from the idle state. The back end takes no new item until a fetch
// has given its result. Reset restores the default sizes and empties queue
// and output; the frame store is not cleared. A stalled receiver holds the
// result word; the queue keeps taking items until it is full, then in_stall rises.
module nearest_neighbor_image_scaler
    import nnis_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PIXEL_BITS = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_word_t           in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_word_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t      cfg;
    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      head;

    nnis_regs #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    nnis_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg      (cfg),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    nnis_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_status (q_status)
    );

    nnis_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: sim/tb_top.sv
// Self-checking testbench of the nearest-neighbor image scaler.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import nnis_pkg::*;

    localparam int          MAX_W       = 256;
    localparam int          MAX_H       = 256;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          DRAIN_WAIT  = 20;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_stall;
    in_word_t           in_data   = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    out_word_t          out_data;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [PADDR_W-1:0] paddr     = '0;
    logic [PDATA_W-1:0] pwdata    = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Size registers as last written
    logic [SRC_SIZE_W-1:0] cfg_src_w = 9'd256;
    logic [SRC_SIZE_W-1:0] cfg_src_h = 9'd256;
    logic [DST_SIZE_W-1:0] cfg_dst_w = 13'd256;
    logic [DST_SIZE_W-1:0] cfg_dst_h = 13'd256;

    // Predicted frame store and which entries the stimulus has loaded
    logic [WORD_W-1:0] pix_mem [0:MAX_W*MAX_H-1];
    bit                loaded  [0:MAX_W*MAX_H-1];

    in_word_t    cmd_words[$];
    out_word_t   want_words[$];
    int          err_cnt = 0;
    int unsigned cyc     = 0;
    logic        quiet;

    nearest_neighbor_image_scaler #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H),
        .PIXEL_BITS (WORD_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // No idling while cyc modulo 6000 is 4500 or more
    assign quiet = (cyc % 6000) >= 4500;

    function automatic bit idle_roll();
        return !quiet && ($urandom_range(99) < 12);
    endfunction

    // Zero acts as one, oversize acts as the limit
    function automatic int unsigned fit(input int unsigned v, input int unsigned top);
        if (v == 0)
            return 1;
        return (v > top) ? top : v;
    endfunction

    // Frame store entry a word touches, or -1 when its coordinate is out of range
    function automatic int store_index(input op_t op, input logic [COORD_W-1:0] x,
                                       input logic [COORD_W-1:0] y);
        int unsigned sw;
        int unsigned sh;
        int unsigned dw;
        int unsigned dh;
        int unsigned sx;
        int unsigned sy;
        sw = fit(cfg_src_w, MAX_W);
        sh = fit(cfg_src_h, MAX_H);
        dw = fit(cfg_dst_w, DST_LIMIT);
        dh = fit(cfg_dst_h, DST_LIMIT);
        if (op == OP_LOAD)
        begin
            if (x >= sw || y >= sh)
                return -1;
            return int'(y) * MAX_W + int'(x);
        end
        if (x >= dw || y >= dh)
            return -1;
        sx = (32'(x) * sw) / dw;
        sy = (32'(y) * sh) / dh;
        return int'(sy) * MAX_W + int'(sx);
    endfunction

    // Queue a word; a fetch of a never-loaded pixel gets a load in front of it
    task automatic push_item(input op_t op, input int unsigned x, input int unsigned y,
                             input logic [WORD_W-1:0] pix);
        in_word_t w;
        int       idx;
        idx = store_index(op, COORD_W'(x), COORD_W'(y));
        if (op == OP_FETCH && idx >= 0 && !loaded[idx])
        begin
            w.op       = OP_LOAD;
            w.x        = COORD_W'(idx % MAX_W);
            w.y        = COORD_W'(idx / MAX_W);
            w.pixel_in = $urandom;
            cmd_words.push_back(w);
        end
        if (idx >= 0)
            loaded[idx] = 1'b1;
        w.op       = op;
        w.x        = COORD_W'(x);
        w.y        = COORD_W'(y);
        w.pixel_in = pix;
        cmd_words.push_back(w);
    endtask

    // Mostly legal loads and fetches, some words anywhere in the coordinate space
    task automatic random_item();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
            push_item(OP_LOAD, $urandom_range(fit(cfg_src_w, MAX_W) - 1),
                      $urandom_range(fit(cfg_src_h, MAX_H) - 1), $urandom);
        else if (r < 85)
            push_item(OP_FETCH, $urandom_range(fit(cfg_dst_w, DST_LIMIT) - 1),
                      $urandom_range(fit(cfg_dst_h, DST_LIMIT) - 1), $urandom);
        else
            push_item(op_t'($urandom_range(1)), $urandom_range(4095),
                      $urandom_range(4095), $urandom);
    endtask

    // Sampled between edges, so queue, valid and pending results are all settled
    task automatic wait_drained();
        while (cmd_words.size() != 0 || in_valid || want_words.size() != 0)
            @(negedge clk);
    endtask

    // Register write: setup cycle, then access until pready
    task automatic reg_write(input reg_idx_t idx, input int unsigned val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_SRC_WIDTH:  cfg_src_w = SRC_SIZE_W'(val);
            REG_SRC_HEIGHT: cfg_src_h = SRC_SIZE_W'(val);
            REG_DST_WIDTH:  cfg_dst_w = DST_SIZE_W'(val);
            REG_DST_HEIGHT: cfg_dst_h = DST_SIZE_W'(val);
            default: ;
        endcase
    endtask

    task automatic run_phase(input int unsigned sw, input int unsigned sh,
                             input int unsigned dw, input int unsigned dh, input int n);
        wait_drained();
        reg_write(REG_SRC_WIDTH, sw);
        reg_write(REG_SRC_HEIGHT, sh);
        reg_write(REG_DST_WIDTH, dw);
        reg_write(REG_DST_HEIGHT, dh);
        repeat (n) random_item();
    endtask

    // Stimulus
    initial
    begin
        int full;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed words at the reset sizes
        push_item(OP_LOAD, 0, 0, 32'hFFFF_FFFF);
        push_item(OP_LOAD, 255, 255, 32'h0000_0000);
        push_item(OP_LOAD, 255, 0, 32'hAAAA_AAAA);
        push_item(OP_LOAD, 0, 255, 32'h5555_5555);
        push_item(OP_LOAD, 256, 0, 32'h1234_5678);
        push_item(OP_LOAD, 0, 256, 32'h8765_4321);
        push_item(OP_LOAD, 4095, 4095, 32'hFFFF_FFFF);
        push_item(OP_FETCH, 0, 0, 32'h0);
        push_item(OP_FETCH, 255, 255, 32'hFFFF_FFFF);
        push_item(OP_FETCH, 255, 0, 32'h0);
        push_item(OP_FETCH, 0, 255, 32'h0);
        push_item(OP_FETCH, 256, 0, 32'h0);
        push_item(OP_FETCH, 0, 256, 32'h0);
        push_item(OP_FETCH, 4095, 4095, 32'hFFFF_FFFF);
        push_item(OP_LOAD, 0, 0, 32'h1234_5678);
        push_item(OP_FETCH, 0, 0, 32'h0);
        push_item(OP_LOAD, 128, 64, 32'h0000_0000);
        push_item(OP_FETCH, 128, 64, 32'h0);

        // Smallest sizes, then zero sizes that act as one
        run_phase(1, 1, 1, 1, 60);
        run_phase(0, 0, 0, 0, 40);

        // Oversize values clamp to the limits; hit the far destination corner
        run_phase(511, 511, 8191, 8191, 90);
        push_item(OP_FETCH, 4095, 4095, 32'h0);
        push_item(OP_FETCH, 4095, 0, 32'h0);
        push_item(OP_FETCH, 0, 4095, 32'h0);

        // Mixed extremes, upscale and downscale
        run_phase(256, 1, 1, 4096, 80);
        run_phase(3, 5, 4096, 17, 100);
        run_phase(200, 150, 7, 9, 100);

        // Random sizes; the last set may leave the legal ranges
        for (int i = 0; i < 4; i++)
        begin
            full = (i == 3);
            run_phase(full ? $urandom_range(511) : $urandom_range(1, 256),
                      full ? $urandom_range(511) : $urandom_range(1, 256),
                      full ? $urandom_range(8191) : $urandom_range(1, 4096),
                      full ? $urandom_range(8191) : $urandom_range(1, 4096), 45);
        end

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_cnt == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Input driver; the result of each taken word is predicted here
    always @(posedge clk)
    begin : drive
        int        idx;
        out_word_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                idx         = store_index(in_data.op, in_data.x, in_data.y);
                want        = '0;
                want.status = (idx < 0) ? STATUS_RANGE : STATUS_OK;
                if (idx >= 0 && in_data.op == OP_LOAD)
                    pix_mem[idx] = in_data.pixel_in;
                else if (idx >= 0)
                    want.pixel_out = pix_mem[idx];
                want_words.push_back(want);
            end
            // Hold a stalled word, otherwise offer the next one or idle
            if (!in_valid || !in_stall)
            begin
                if (cmd_words.size() != 0 && !idle_roll())
                begin
                    in_valid <= 1'b1;
                    in_data  <= cmd_words.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor and random output stall
    always @(posedge clk)
    begin : check
        out_word_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (want_words.size() == 0)
                begin
                    $error("unexpected result word: pixel_out %h status %0d",
                           out_data.pixel_out, out_data.status);
                    err_cnt++;
                end
                else
                begin
                    want = want_words.pop_front();
                    if (out_data.pixel_out !== want.pixel_out)
                    begin
                        $error("pixel_out: expected %h, got %h",
                               want.pixel_out, out_data.pixel_out);
                        err_cnt++;
                    end
                    if (out_data.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, out_data.status);
                        err_cnt++;
                    end
                end
            end
            out_stall <= idle_roll();
        end
    end

    // Cycle count and timeout
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT)
        begin
            $display("tb_top failed");
            $finish;
        end
    end

endmodule

// File: filelist.f
src/nnis_pkg.sv
src/nnis_regs.sv
src/nnis_front.sv
src/nnis_queue.sv
src/nnis_back.sv
src/nearest_neighbor_image_scaler.sv
sim/tb_top.sv
